// ===== design/srd_pkg.sv =====
package srd_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int SUM_WIDTH       = 36;
    localparam int COUNT_OUT_WIDTH = 5;
    localparam int QUEUE_DEPTH     = 2;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_out;
        logic                         keep;
        logic [COUNT_OUT_WIDTH-1:0]   distinct_count;
        logic [COUNT_OUT_WIDTH-1:0]   removed_count;
        logic signed [SUM_WIDTH-1:0]  kept_sum;
        logic                         overflow;
        logic                         end_of_list;
    } out_word_t;

    // verdict handed from the classifier to the accumulator
    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
        logic                  keep;
        logic                  dup;
    } class_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

// ===== design/srd_queue.sv =====
module srd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srd_pkg::class_t       push_data,
    input  logic                  pop,
    output srd_pkg::class_t       pop_data,
    output srd_pkg::queue_status_t status
);
    import srd_pkg::*;

    localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    class_t                entries_reg [DEPTH];
    logic [PTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_WIDTH-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == CNT_WIDTH'(DEPTH));
    assign status.valid = (count_reg != '0);
    assign pop_data     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/srd_front.sv =====
module srd_front #(
    parameter int MAX_ITEMS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  srd_pkg::in_word_t      in_data,
    input  srd_pkg::queue_status_t q_status,
    output logic                   push,
    output srd_pkg::class_t        push_data
);
    import srd_pkg::*;

    localparam int KEY_WIDTH = (VALUE_WIDTH < DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
    localparam int CNT_WIDTH = $clog2(MAX_ITEMS + 1);
    localparam int IDX_WIDTH = $clog2(MAX_ITEMS);

    typedef enum logic {IDLE, CLASSIFY} state_t;

    state_t                state_reg, state_next;
    logic [CNT_WIDTH-1:0]  seen_count_reg, seen_count_next;
    logic [CNT_WIDTH-1:0]  item_count_reg, item_count_next;
    logic [KEY_WIDTH-1:0]  cells_reg [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  match_reg, match_next;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  last_reg;
    logic                  accept;
    logic                  ovf, dup, keep;

    assign in_ready = (state_reg == IDLE) && !q_status.full;
    assign accept   = in_valid && in_ready;

    // one comparator per cell; cells at or above the fill count never match
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            match_next[i] = (cells_reg[i] == in_data.value[KEY_WIDTH-1:0])
                            && (CNT_WIDTH'(i) < seen_count_reg);
        end
    end

    assign ovf  = (item_count_reg >= CNT_WIDTH'(MAX_ITEMS));
    assign dup  = !ovf && (|match_reg);
    assign keep = !ovf && !dup;

    assign push           = (state_reg == CLASSIFY);
    assign push_data.value = value_reg;
    assign push_data.last  = last_reg;
    assign push_data.keep  = keep;
    assign push_data.dup   = dup;

    always_comb
    begin
        state_next      = state_reg;
        seen_count_next = seen_count_reg;
        item_count_next = item_count_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    state_next = CLASSIFY;
                end
            end
            CLASSIFY:
            begin
                state_next = IDLE;
                if (!ovf)
                begin
                    item_count_next = item_count_reg + 1'b1;
                end
                if (keep)
                begin
                    seen_count_next = seen_count_reg + 1'b1;
                end
                if (last_reg)
                begin
                    item_count_next = '0;
                    seen_count_next = '0;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            seen_count_reg <= '0;
            item_count_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            seen_count_reg <= seen_count_next;
            item_count_reg <= item_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= in_data.value;
            last_reg  <= in_data.last;
            match_reg <= match_next;
        end
        if (push && keep)
        begin
            cells_reg[seen_count_reg[IDX_WIDTH-1:0]] <= value_reg[KEY_WIDTH-1:0];
        end
    end

endmodule

// ===== design/srd_back.sv =====
module srd_back #(
    parameter int MAX_ITEMS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  srd_pkg::queue_status_t q_status,
    input  srd_pkg::class_t        q_data,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output srd_pkg::out_word_t     out_data
);
    import srd_pkg::*;

    localparam int KEY_WIDTH = (VALUE_WIDTH < DATA_WIDTH) ? VALUE_WIDTH : DATA_WIDTH;
    localparam int CNT_WIDTH = $clog2(MAX_ITEMS + 1);

    logic [CNT_WIDTH-1:0]  distinct_reg, distinct_next, distinct_new;
    logic [CNT_WIDTH-1:0]  removed_reg, removed_next, removed_new;
    logic [SUM_WIDTH-1:0]  sum_reg, sum_next, sum_new;
    logic [SUM_WIDTH-1:0]  addend;
    logic                  out_valid_reg, out_valid_next;
    out_word_t             out_data_reg, out_data_next;

    // narrow values are signed; wider settings see the 32-bit word as unsigned
    generate
        if (VALUE_WIDTH <= DATA_WIDTH)
        begin : g_sext
            assign addend = {{(SUM_WIDTH - KEY_WIDTH){q_data.value[KEY_WIDTH-1]}},
                             q_data.value[KEY_WIDTH-1:0]};
        end
        else
        begin : g_zext
            assign addend = {{(SUM_WIDTH - DATA_WIDTH){1'b0}}, q_data.value};
        end
    endgenerate

    assign pop       = q_status.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign distinct_new = distinct_reg + CNT_WIDTH'(q_data.keep);
    assign removed_new  = removed_reg + CNT_WIDTH'(q_data.dup);
    assign sum_new      = q_data.keep ? sum_reg + addend : sum_reg;

    always_comb
    begin
        distinct_next  = distinct_reg;
        removed_next   = removed_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            out_valid_next               = 1'b1;
            out_data_next.value_out      = q_data.value;
            out_data_next.keep           = q_data.keep;
            out_data_next.distinct_count = COUNT_OUT_WIDTH'(distinct_new);
            out_data_next.removed_count  = COUNT_OUT_WIDTH'(removed_new);
            out_data_next.kept_sum       = sum_new;
            out_data_next.overflow       = !q_data.keep && !q_data.dup;
            out_data_next.end_of_list    = q_data.last;
            if (q_data.last)
            begin
                distinct_next = '0;
                removed_next  = '0;
                sum_next      = '0;
            end
            else
            begin
                distinct_next = distinct_new;
                removed_next  = removed_new;
                sum_next      = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distinct_reg  <= '0;
            removed_reg   <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            distinct_reg  <= distinct_next;
            removed_reg   <= removed_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ===== design/stream_duplicate_remover.sv =====
// Order-preserving duplicate removal over lists of up to MAX_ITEMS words, the
// final word of each list marked by last. Every word gives one result: the word
// itself, whether it was kept (first occurrence), running distinct and removed
// counts, and the 36-bit sum of kept values; words beyond MAX_ITEMS in a list
// come back with overflow set and change nothing. The classifier compares each
// word against all stored values at once, one comparator per cell, registers
// the match vector, then decides and stores in the following cycle, so it takes
// no new word until it has decided the last one; that two-step classify loop
// sets the rate. A 2-word queue and a registered output let the accumulator
// drain results while the classifier works. The value store needs no clearing
// after reset or at the end of a list: only cells below the fill count take
// part in the compare.
module stream_duplicate_remover #(
    parameter int MAX_ITEMS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  srd_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output srd_pkg::out_word_t out_data
);
    import srd_pkg::*;

    localparam bit COUNT_FITS = (MAX_ITEMS < (1 << COUNT_OUT_WIDTH));

    queue_status_t q_status;
    class_t        push_data, pop_data;
    logic          push, pop;

    srd_front #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    srd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    srd_back #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // classifier is busy for the cycle after it takes a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while classifier busy");

    a_keep_not_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.keep && out_data.overflow))
        else $error("word both kept and overflowed");

    a_keep_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (COUNT_FITS && out_valid && out_data.keep) |-> (out_data.distinct_count != '0))
        else $error("kept word with zero distinct count");

    // a word kept by the classifier is never also marked as a repeat
    a_verdict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !(push_data.keep && push_data.dup))
        else $error("verdict both keep and duplicate");

endmodule

// ===== dv/srd_checker.sv =====
`timescale 1ns / 1ps
module srd_checker #(
    parameter int MAX_ITEMS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  srd_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  srd_pkg::out_word_t out_data,
    output int                 errors,
    output int                 pending
);
    import srd_pkg::*;

    // predictor state for the current list
    logic [DATA_WIDTH-1:0] seen_store [MAX_ITEMS];
    int unsigned           seen_fill;
    int unsigned           list_len;
    int unsigned           dup_total;
    logic [SUM_WIDTH-1:0]  kept_total;

    out_word_t expected_words [$];
    int        err_count = 0;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $time, field, got, want);
        err_count++;
    endtask

    task automatic dedup_predict(input in_word_t w, output out_word_t r);
        logic        hit;
        int unsigned i;
        hit = 1'b0;
        r = '0;
        r.value_out = w.value;
        r.end_of_list = w.last;
        if (list_len >= MAX_ITEMS)
        begin
            // beyond the list limit: dropped, totals untouched
            r.overflow = 1'b1;
        end
        else
        begin
            list_len++;
            for (i = 0; i < seen_fill; i++)
                if (seen_store[i] == w.value)
                    hit = 1'b1;
            if (hit)
                dup_total++;
            else
            begin
                seen_store[seen_fill] = w.value;
                seen_fill++;
                kept_total = kept_total
                    + {{(SUM_WIDTH-DATA_WIDTH){w.value[DATA_WIDTH-1]}}, w.value};
                r.keep = 1'b1;
            end
        end
        r.distinct_count = COUNT_OUT_WIDTH'(seen_fill);
        r.removed_count  = COUNT_OUT_WIDTH'(dup_total);
        r.kept_sum       = kept_total;
        if (w.last)
        begin
            seen_fill  = 0;
            list_len   = 0;
            dup_total  = 0;
            kept_total = '0;
        end
    endtask

    task automatic compare_word(input out_word_t got, input out_word_t want);
        if (got.value_out !== want.value_out)
            report_mismatch("value_out", got.value_out, want.value_out);
        if (got.keep !== want.keep)
            report_mismatch("keep", got.keep, want.keep);
        if (got.distinct_count !== want.distinct_count)
            report_mismatch("distinct_count", got.distinct_count, want.distinct_count);
        if (got.removed_count !== want.removed_count)
            report_mismatch("removed_count", got.removed_count, want.removed_count);
        if (got.kept_sum !== want.kept_sum)
            report_mismatch("kept_sum", got.kept_sum, want.kept_sum);
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        if (got.end_of_list !== want.end_of_list)
            report_mismatch("end_of_list", got.end_of_list, want.end_of_list);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            seen_fill  = 0;
            list_len   = 0;
            dup_total  = 0;
            kept_total = '0;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", out_data.value_out, '0);
                else
                begin
                    want = expected_words.pop_front();
                    compare_word(out_data, want);
                end
            end
            if (in_valid && in_ready)
            begin
                dedup_predict(in_data, want);
                expected_words.push_back(want);
            end
        end
        errors  <= err_count;
        pending <= expected_words.size();
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import srd_pkg::*;

    localparam int MAX_ITEMS    = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 12;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 1825;
    localparam int POOL_DEPTH   = 8;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    int errors;
    int pending;
    int idle_cycles = 0;
    int hold_tok    = 0;
    int burst_left  = 0;

    logic signed [DATA_WIDTH-1:0] pool [POOL_DEPTH];
    int                           pool_size;

    always #1 clk = ~clk;

    stream_duplicate_remover #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    srd_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    // nothing moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic go_idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 3))
                0:       ;
                1, 2:    go_idle($urandom_range(1, 4));
                default: go_idle($urandom_range(5, 20));
            endcase
        end
    endtask

    task automatic send_item(input logic signed [DATA_WIDTH-1:0] v, input logic l);
        @(negedge clk);
        in_data  <= '{value: v, last: l};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pace();
    endtask

    task automatic wait_drained();
        go_idle(1);
        while (pending != 0)
            @(negedge clk);
        go_idle(TAIL_CYCLES);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pool[$urandom_range(0, pool_size - 1)];
        else if (r < 9)
            return $urandom;
        else
            case ($urandom_range(0, 4))
                0:       return {1'b1, {(DATA_WIDTH-1){1'b0}}};
                1:       return {1'b0, {(DATA_WIDTH-1){1'b1}}};
                2:       return '0;
                3:       return '1;
                default: return 1;
            endcase
    endfunction

    // receiver: ready pattern changes mode every so often
    initial
    begin : receiver
        int mode;
        int span;
        int seen_tok;
        int k;
        seen_tok = 0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (hold_tok != seen_tok)
                begin
                    // long hold-off so the block backs up into its input
                    seen_tok = hold_tok;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge clk);
                end
                else
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= $urandom_range(0, 1);
                        2:       out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= (k % 4 != 3);
                    endcase
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int j;
        int len;
        int sent;
        int list_no;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        go_idle(3);

        // extremes, repeats of them, negative running sum
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(32'shFFFF_FFFF, 1'b0);
        send_item(32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh8000_0000, 1'b1);
        // list of one word
        send_item(32'sh5A5A_5A5A, 1'b1);
        // large sum, repeats, then overflow words, the last one ending the list
        for (i = 0; i < 12; i++)
            send_item(32'sh7FFF_FFF0 + i, 1'b0);
        send_item(32'sh7FFF_FFF0, 1'b0);
        send_item(32'sh7FFF_FFF3, 1'b0);
        send_item(32'sh7FFF_FFF7, 1'b0);
        send_item(32'sh7FFF_FFFB, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh1234_5678, 1'b1);
        wait_drained();

        sent = 0;
        list_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 6) == 0)
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            else
                len = $urandom_range(1, MAX_ITEMS);
            pool_size = $urandom_range(1, POOL_DEPTH);
            for (i = 0; i < POOL_DEPTH; i++)
                pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15) - 8;
            for (j = 0; j < len; j++)
                send_item(pick_value(), j == len - 1);
            sent += len;
            list_no++;
            if (list_no == 20 || list_no == 90)
            begin
                hold_tok = hold_tok + 1;
                burst_left = 60;
            end
            if (list_no % 40 == 0)
                wait_drained();
        end

        wait_drained();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/srd_pkg.sv
design/srd_queue.sv
design/srd_front.sv
design/srd_back.sv
design/stream_duplicate_remover.sv
dv/srd_checker.sv
dv/tb_top.sv
